@@ rtl/dpae_pkg.sv @@
// shared types and constants for the dns ptr answer extractor
`default_nettype none
package dpae_pkg;

  // field widths fixed by the byte stream format
  localparam int POS_W  = 10;
  localparam int NPOS_W = 17;
  localparam int LEN_W  = 11;

  // request codes
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // header byte offsets
  localparam logic [POS_W-1:0] HDR_QD_HI = 10'd4;
  localparam logic [POS_W-1:0] HDR_QD_LO = 10'd5;
  localparam logic [POS_W-1:0] HDR_AN_HI = 10'd6;
  localparam logic [POS_W-1:0] HDR_AN_LO = 10'd7;
  localparam logic [POS_W-1:0] HDR_LAST  = 10'd11;
  localparam logic [LEN_W-1:0] HDR_LEN   = 11'd12;

  // fixed answer part offsets
  localparam logic [POS_W-1:0] FX_TYPE_HI = 10'd0;
  localparam logic [POS_W-1:0] FX_TYPE_LO = 10'd1;
  localparam logic [POS_W-1:0] FX_RDL_HI  = 10'd8;
  localparam logic [POS_W-1:0] FX_RDL_LO  = 10'd9;

  localparam logic [NPOS_W-1:0] FIXED_LEN = 17'd10;
  localparam logic [NPOS_W-1:0] QTAIL_LEN = 17'd5;
  localparam logic [NPOS_W-1:0] PTR_LEN   = 17'd2;
  localparam logic [NPOS_W-1:0] ONE_POS   = 17'd1;
  localparam logic [POS_W-1:0]  POS_MAX   = 10'd1023;

  localparam logic [7:0]  PTR_MARK  = 8'hC0;
  localparam logic [7:0]  DOT_CHAR  = 8'h2E;
  localparam logic [15:0] TYPE_PTR  = 16'd12;

  // parse phases, one-hot
  typedef enum logic [6:0] {
    PH_HEADER = 7'b0000001,
    PH_QNAME  = 7'b0000010,
    PH_ASTART = 7'b0000100,
    PH_ANAME  = 7'b0001000,
    PH_FIXED  = 7'b0010000,
    PH_RDATA  = 7'b0100000,
    PH_IDLE   = 7'b1000000
  } phase_t;

  // one input request
  typedef struct packed {
    logic             req_type;
    logic [7:0]       data_byte;
    logic [POS_W-1:0] packet_len;
    logic             first_byte;
  } req_t;

  // one result
  typedef struct packed {
    logic [7:0] name_char;
    logic       char_valid;
    logic       name_done;
    logic [3:0] service_index;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/dpae_core.sv @@
// parse state and per-byte next-state logic of the extractor
`default_nettype none
module dpae_core #(
  parameter int MAX_SERVICES = 16,
  parameter int MAX_PACKET   = 512,
  parameter int NAME_LIMIT   = 31
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             step,
  input  dpae_pkg::req_t  req,
  output dpae_pkg::res_t  res,
  output logic            res_hit
);
  import dpae_pkg::*;

  localparam int CNT_W = $clog2(MAX_SERVICES + 1);
  localparam int NL_W  = $clog2(NAME_LIMIT + 1);
  localparam logic [LEN_W-1:0] MAXP    = LEN_W'(MAX_PACKET);
  localparam logic [CNT_W-1:0] MAXS    = CNT_W'(MAX_SERVICES);
  localparam logic [NL_W-1:0]  NLIM    = NL_W'(NAME_LIMIT);
  localparam logic [NL_W-1:0]  NL_ONE  = NL_W'(1);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  phase_t              phase_r, phase_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [NPOS_W-1:0]   np_r, np_nxt;
  logic [15:0]         ql_r, ql_nxt;
  logic [15:0]         al_r, al_nxt;
  logic [15:0]         rt_r, rt_nxt;
  logic [7:0]          rdl_hi_r, rdl_hi_nxt;
  logic [NPOS_W-1:0]   re_r, re_nxt;
  logic [7:0]          ll_r, ll_nxt;
  logic [NL_W-1:0]     nl_r, nl_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  phase_t              ph;
  logic [POS_W-1:0]    pos;
  logic [NPOS_W-1:0]   pos17;
  logic [LEN_W-1:0]    len;
  logic [NPOS_W:0]     fx_end;
  logic [POS_W-1:0]    off;
  logic [15:0]         rdl_full;
  logic [15:0]         qdec;
  logic [NPOS_W-1:0]   start;
  logic [NPOS_W:0]     rd_end;
  logic                fin;
  logic [CNT_W+3:0]    cnt_ext;
  logic [7:0]          chr;
  logic                cv;
  logic                done;

  // next state and result for the request at the input register
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    np_nxt     = np_r;
    ql_nxt     = ql_r;
    al_nxt     = al_r;
    rt_nxt     = rt_r;
    rdl_hi_nxt = rdl_hi_r;
    re_nxt     = re_r;
    ll_nxt     = ll_r;
    nl_nxt     = nl_r;
    cnt_nxt    = cnt_r;
    chr        = '0;
    cv         = 1'b0;
    done       = 1'b0;
    fin        = 1'b0;
    ph         = req.first_byte ? PH_HEADER : phase_r;
    pos        = req.first_byte ? '0 : pos_r;
    pos17      = {{(NPOS_W-POS_W){1'b0}}, pos};
    len        = ({1'b0, req.packet_len} > MAXP) ? MAXP : {1'b0, req.packet_len};
    fx_end     = {1'b0, np_r} + {1'b0, FIXED_LEN};
    off        = POS_W'(pos17 - np_r);
    rdl_full   = {rdl_hi_r, req.data_byte};
    qdec       = ql_r - 16'd1;
    start      = np_r + FIXED_LEN;
    rd_end     = {1'b0, start} + {{(NPOS_W-15){1'b0}}, rdl_full};
    cnt_ext    = {4'b0, cnt_r};

    if (req.req_type == REQ_CLEAR) begin
      cnt_nxt = '0;
    end else begin
      phase_nxt = ph;
      pos_nxt   = (pos != POS_MAX) ? pos + 10'd1 : pos;
      if ({1'b0, pos} < len) begin
        case (ph)
          PH_HEADER: begin
            if (len < HDR_LEN) begin
              phase_nxt = PH_IDLE;
            end else begin
              case (pos)
                HDR_QD_HI: ql_nxt = {req.data_byte, 8'h00};
                HDR_QD_LO: ql_nxt = {ql_r[15:8], req.data_byte};
                HDR_AN_HI: al_nxt = {req.data_byte, 8'h00};
                HDR_AN_LO: al_nxt = {al_r[15:8], req.data_byte};
                HDR_LAST: begin
                  np_nxt = NPOS_W'(HDR_LEN);
                  if (al_r == 16'd0)      phase_nxt = PH_IDLE;
                  else if (ql_r == 16'd0) phase_nxt = PH_ASTART;
                  else                    phase_nxt = PH_QNAME;
                end
                default: ;
              endcase
            end
          end
          PH_QNAME: begin
            if (pos17 >= np_r && req.data_byte == 8'h00) begin
              ql_nxt = qdec;
              np_nxt = pos17 + QTAIL_LEN;
              if (qdec == 16'd0) phase_nxt = PH_ASTART;
            end
          end
          PH_ASTART: begin
            if (pos17 >= np_r) begin
              if (al_r == 16'd0 || cnt_r >= MAXS) begin
                phase_nxt = PH_IDLE;
              end else begin
                al_nxt = al_r - 16'd1;
                if (req.data_byte == PTR_MARK) begin
                  np_nxt    = pos17 + PTR_LEN;
                  phase_nxt = PH_FIXED;
                end else if (req.data_byte == 8'h00) begin
                  np_nxt    = pos17 + ONE_POS;
                  phase_nxt = PH_FIXED;
                end else begin
                  phase_nxt = PH_ANAME;
                end
              end
            end
          end
          PH_ANAME: begin
            if (req.data_byte == 8'h00) begin
              np_nxt    = pos17 + ONE_POS;
              phase_nxt = PH_FIXED;
            end
          end
          PH_FIXED: begin
            if (pos17 >= np_r) begin
              case (off)
                FX_TYPE_HI: begin
                  if (fx_end > {{(NPOS_W-LEN_W+1){1'b0}}, len}) phase_nxt = PH_IDLE;
                  else rt_nxt = {req.data_byte, 8'h00};
                end
                FX_TYPE_LO: rt_nxt = {rt_r[15:8], req.data_byte};
                FX_RDL_HI:  rdl_hi_nxt = req.data_byte;
                FX_RDL_LO: begin
                  rdl_hi_nxt = rdl_hi_r;
                  if (rt_r == TYPE_PTR && rdl_full != 16'd0 &&
                      rd_end <= {{(NPOS_W-LEN_W+1){1'b0}}, len}) begin
                    np_nxt    = start;
                    re_nxt    = rd_end[NPOS_W-1:0];
                    nl_nxt    = '0;
                    ll_nxt    = '0;
                    phase_nxt = PH_RDATA;
                  end else begin
                    np_nxt    = rd_end[NPOS_W-1:0];
                    phase_nxt = PH_ASTART;
                  end
                end
                default: ;
              endcase
            end
          end
          PH_RDATA: begin
            if (pos17 >= np_r) begin
              // label length byte or label character
              if (ll_r == 8'd0) begin
                if (req.data_byte == 8'h00 || req.data_byte == PTR_MARK) begin
                  fin = 1'b1;
                end else begin
                  if (nl_r != '0) begin
                    chr    = DOT_CHAR;
                    cv     = 1'b1;
                    nl_nxt = nl_r + NL_ONE;
                  end
                  ll_nxt = req.data_byte;
                end
              end else begin
                chr    = req.data_byte;
                cv     = 1'b1;
                nl_nxt = nl_r + NL_ONE;
                ll_nxt = ll_r - 8'd1;
              end
              if (nl_nxt >= NLIM || (pos17 + ONE_POS) >= re_r) fin = 1'b1;
              // end of name: commit if anything was emitted
              if (fin) begin
                if (nl_nxt != '0) begin
                  done    = 1'b1;
                  cnt_nxt = cnt_r + CNT_ONE;
                end
                np_nxt    = re_r;
                phase_nxt = PH_ASTART;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign res.name_char     = chr;
  assign res.char_valid    = cv;
  assign res.name_done     = done;
  assign res.service_index = cnt_ext[3:0];
  assign res_hit           = cv | done;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      np_r    <= '0;
      ql_r    <= '0;
      al_r    <= '0;
      rt_r    <= '0;
      rdl_hi_r <= '0;
      re_r    <= '0;
      ll_r    <= '0;
      nl_r    <= '0;
      cnt_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      np_r    <= np_nxt;
      ql_r    <= ql_nxt;
      al_r    <= al_nxt;
      rt_r    <= rt_nxt;
      rdl_hi_r <= rdl_hi_nxt;
      re_r    <= re_nxt;
      ll_r    <= ll_nxt;
      nl_r    <= nl_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // service count stays within the table
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAXS) else $error("service count above table size");

  // name length stays within the limit
  a_nl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nl_r <= NLIM) else $error("name length above limit");

  // a commit advances the service count by one
  a_commit: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_hit && res.name_done |=> cnt_r == $past(cnt_r) + CNT_ONE)
    else $error("commit did not advance service count");

  // characters only come out while reading rdata
  a_char_phase: assert property (@(posedge clk) disable iff (!rst_n)
    res.char_valid |-> phase_r == PH_RDATA && !req.first_byte)
    else $error("character outside rdata");

endmodule
`default_nettype wire

@@ rtl/dns_ptr_answer_extractor_unit.sv @@
// top level of the dns ptr answer extractor: request and result registers
//
//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  in      | in_valid in_ready in_req_type in_data_byte         | request in
//          | in_packet_len in_first_byte                        |
//  out     | out_valid out_ready out_name_char out_char_valid   | result out
//          | out_name_done out_service_index                    |
//
// one request per cycle sustained while no held result stalls; a request waits in the request
// register, where the parse logic updates the state and loads the result register.
// result valid rises as the result register loads, which waits until the output is free.
// synchronous active-low reset clears parse state and service count.
// a held result stalls only requests that make a result; others pass through.
`default_nettype none
module dns_ptr_answer_extractor_unit #(
  parameter int MAX_SERVICES = 16,
  parameter int MAX_PACKET   = 512,
  parameter int NAME_LIMIT   = 31
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        in_req_type,
  input  wire  [7:0] in_data_byte,
  input  wire  [9:0] in_packet_len,
  input  wire        in_first_byte,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] out_name_char,
  output logic       out_char_valid,
  output logic       out_name_done,
  output logic [3:0] out_service_index
);
  import dpae_pkg::*;

  logic   req_valid_r;
  req_t   req_r;
  res_t   res;
  logic   res_hit;
  logic   step;
  logic   out_valid_r;
  res_t   out_res_r;

  // request moves on unless its result would hit a held output
  assign step     = req_valid_r && (!out_valid_r || out_ready || !res_hit);
  assign in_ready = !req_valid_r || step;

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      req_valid_r <= 1'b1;
    end else if (step) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.req_type   <= in_req_type;
      req_r.data_byte  <= in_data_byte;
      req_r.packet_len <= in_packet_len;
      req_r.first_byte <= in_first_byte;
    end
  end

  dpae_core #(
    .MAX_SERVICES (MAX_SERVICES),
    .MAX_PACKET   (MAX_PACKET),
    .NAME_LIMIT   (NAME_LIMIT)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .req     (req_r),
    .res     (res),
    .res_hit (res_hit)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && res_hit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_hit) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_name_char     = out_res_r.name_char;
  assign out_char_valid    = out_res_r.char_valid;
  assign out_name_done     = out_res_r.name_done;
  assign out_service_index = out_res_r.service_index;

  // a waiting request is never dropped
  a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid_r && !step |=> req_valid_r) else $error("request lost");

  // a held result is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(step && res_hit)) else $error("result overrun");

  // a waiting result keeps its valid and its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_res_r))
    else $error("result changed while held");

endmodule
`default_nettype wire
